// ===== hw/rtl/hbe_pkg.sv =====
// Package for the Huffman byte encoder: constants, command and result codes,
// heap entry and result types. No dependencies.
`default_nettype none
package hbe_pkg;

   localparam int SYMBOLS       = 256;
   localparam int MAX_CODE_BITS = 64;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_COUNT  = 3'd1;
   localparam logic [2:0] CMD_BUILD  = 3'd2;
   localparam logic [2:0] CMD_ENCODE = 3'd3;
   localparam logic [2:0] CMD_FLUSH  = 3'd4;
   localparam logic [2:0] CMD_FREQ   = 3'd5;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_FREQ    = 2'd2;

   typedef struct packed {
      logic [31:0] weight;
      logic [8:0]  node;
   } heap_entry_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  out_byte;
      logic [8:0]  symbol_count;
      logic [47:0] total_count;
      logic [31:0] frequency;
      logic        error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage
`default_nettype wire

// ===== hw/rtl/hbe_req_if.sv =====
// Request channel interface of the Huffman byte encoder.
// Depends on nothing.
`default_nettype none
interface hbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hbe_rsp_if.sv =====
// Result channel interface of the Huffman byte encoder.
// Depends on nothing.
`default_nettype none
interface hbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  out_byte;
   logic [8:0]  symbol_count;
   logic [47:0] total_count;
   logic [31:0] frequency;
   logic        error;
   logic        last;

   modport source (output valid, result_kind, out_byte, symbol_count, total_count,
                   frequency, error, last, input ready);
   modport sink (input valid, result_kind, out_byte, symbol_count, total_count,
                 frequency, error, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hbe_core.sv =====
// Sequencer and memories of the Huffman byte encoder: histogram, heap,
// tree children, tree walk and code tables. Depends on hbe_pkg.
`default_nettype none
module hbe_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_command,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              out_free,
   output hbe_pkg::emit_type      emit
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CNT     = 5'd1;
   localparam logic [4:0] S_FREQ    = 5'd2;
   localparam logic [4:0] S_ENC     = 5'd3;
   localparam logic [4:0] S_PACK    = 5'd4;
   localparam logic [4:0] S_FLUSH   = 5'd5;
   localparam logic [4:0] S_SCAN_RD = 5'd6;
   localparam logic [4:0] S_SCAN_CK = 5'd7;
   localparam logic [4:0] S_SCAN_NX = 5'd8;
   localparam logic [4:0] S_AFTER   = 5'd9;
   localparam logic [4:0] S_LONE    = 5'd10;
   localparam logic [4:0] S_INS_RD  = 5'd11;
   localparam logic [4:0] S_INS_CK  = 5'd12;
   localparam logic [4:0] S_EX0     = 5'd13;
   localparam logic [4:0] S_EX1     = 5'd14;
   localparam logic [4:0] S_EX2     = 5'd15;
   localparam logic [4:0] S_SD_L    = 5'd16;
   localparam logic [4:0] S_SD_R    = 5'd17;
   localparam logic [4:0] S_SD_CK   = 5'd18;
   localparam logic [4:0] S_M_A     = 5'd19;
   localparam logic [4:0] S_M_B     = 5'd20;
   localparam logic [4:0] S_M_NX    = 5'd21;
   localparam logic [4:0] S_W_RD    = 5'd22;
   localparam logic [4:0] S_W_C0    = 5'd23;
   localparam logic [4:0] S_W_C1    = 5'd24;
   localparam logic [4:0] S_DONE    = 5'd25;

   localparam logic [47:0] TOTAL_MAX = '1;

   // memories
   logic [31:0]                   hist_mem [hbe_pkg::SYMBOLS];
   hbe_pkg::heap_entry_type       heap_mem [256];
   logic [8:0]                    kid_l_mem [256];
   logic [8:0]                    kid_r_mem [256];
   logic [63:0]                   walk_code_mem [256];
   logic [7:0]                    walk_depth_mem [256];
   logic [63:0]                   code_word_mem [hbe_pkg::SYMBOLS];
   logic [6:0]                    code_len_mem [hbe_pkg::SYMBOLS];

   // registered read data
   logic [31:0]                   hist_rd_ff;
   logic                          hv_rd_ff;
   hbe_pkg::heap_entry_type       heap_rd_ff;
   logic [8:0]                    kid_l_rd_ff, kid_r_rd_ff;
   logic [63:0]                   walk_code_rd_ff;
   logic [7:0]                    walk_depth_rd_ff;
   logic [63:0]                   cw_rd_ff;
   logic [6:0]                    cl_rd_ff;
   logic                          cv_rd_ff;

   // control state
   logic [4:0]   state_ff, state_in;
   logic [4:0]   ret_ff, ret_in;
   logic [7:0]   byte_ff, byte_in;
   logic [hbe_pkg::SYMBOLS-1:0] hv_ff, cv_ff;
   logic [8:0]   distinct_ff, distinct_in;
   logic [47:0]  total_ff, total_in;
   logic [7:0]   buf_ff, buf_in;
   logic [2:0]   pend_ff, pend_in;
   logic         ready_ff, ready_in;

   // build and pack working registers
   logic [8:0]   size_ff, size_in;
   logic [7:0]   s_ff, s_in;
   logic [8:0]   next_ff, next_in;
   logic [7:0]   ins_i_ff, ins_i_in;
   logic [7:0]   sd_i_ff, sd_i_in;
   hbe_pkg::heap_entry_type ins_ff, ins_in, top_ff, top_in, x_ff, x_in;
   hbe_pkg::heap_entry_type a_ff, a_in, hl_ff, hl_in;
   logic         rv_ff, rv_in;
   logic [63:0]  al_ff, al_in;
   logic [6:0]   bits_ff, bits_in;

   // memory controls
   logic         hist_re, hist_we, hist_clr;
   logic [7:0]   hist_ra, hist_wa;
   logic [31:0]  hist_wd;
   logic         heap_re, heap_we;
   logic [7:0]   heap_ra, heap_wa;
   hbe_pkg::heap_entry_type heap_wd;
   logic         kid_we, walk_re, walk_we;
   logic [7:0]   kid_wa, walk_ra, walk_wa;
   logic [8:0]   kid_wl, kid_wr;
   logic [63:0]  walk_wcode;
   logic [7:0]   walk_wdepth;
   logic         code_re, code_we, code_clr;
   logic [7:0]   code_ra, code_wa;
   logic [63:0]  code_wword;
   logic [6:0]   code_wlen;

   // datapath helpers
   logic         accept;
   logic         sym_ok;
   logic [31:0]  hist_val, hist_inc;
   logic [8:0]   parent;
   logic [8:0]   l_idx;
   logic [9:0]   r_idx;
   logic [31:0]  cur_w;
   logic         pick_l, pick_r;
   logic [8:0]   child;
   logic [7:0]   child_depth;
   logic [63:0]  child_code;
   logic [3:0]   room, take, pend_sum;
   logic [15:0]  combo;
   logic [6:0]   rem;
   hbe_pkg::rsp_type rsp_d;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign sym_ok    = ({1'b0, byte_ff} < 9'(hbe_pkg::SYMBOLS));
   assign hist_val  = hv_rd_ff ? hist_rd_ff : 32'd0;
   assign hist_inc  = hist_val + 32'd1;
   assign parent    = {1'b0, ins_i_ff} - 9'd1;
   assign l_idx     = {sd_i_ff, 1'b1};
   assign r_idx     = {1'b0, sd_i_ff, 1'b0} + 10'd2;
   assign room      = 4'd8 - {1'b0, pend_ff};
   assign take      = (bits_ff >= {3'b0, room}) ? room : bits_ff[3:0];
   assign combo     = {buf_ff, al_ff[63:56]} << take;
   assign pend_sum  = {1'b0, pend_ff} + take;
   assign rem       = bits_ff - {3'b0, take};
   assign child       = (state_ff == S_W_C1) ? kid_r_rd_ff : kid_l_rd_ff;
   assign child_depth = walk_depth_rd_ff + 8'd1;
   assign child_code  = {walk_code_rd_ff[62:0], (state_ff == S_W_C1)};

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      byte_in     = byte_ff;
      distinct_in = distinct_ff;
      total_in    = total_ff;
      buf_in      = buf_ff;
      pend_in     = pend_ff;
      ready_in    = ready_ff;
      size_in     = size_ff;
      s_in        = s_ff;
      next_in     = next_ff;
      ins_i_in    = ins_i_ff;
      sd_i_in     = sd_i_ff;
      ins_in      = ins_ff;
      top_in      = top_ff;
      x_in        = x_ff;
      a_in        = a_ff;
      hl_in       = hl_ff;
      rv_in       = rv_ff;
      al_in       = al_ff;
      bits_in     = bits_ff;

      hist_re = 1'b0; hist_we = 1'b0; hist_clr = 1'b0;
      hist_ra = req_data_byte; hist_wa = byte_ff; hist_wd = hist_inc;
      heap_re = 1'b0; heap_we = 1'b0; heap_ra = '0; heap_wa = '0; heap_wd = ins_ff;
      kid_we = 1'b0; kid_wa = next_ff[7:0]; kid_wl = a_ff.node; kid_wr = top_ff.node;
      walk_re = 1'b0; walk_ra = next_ff[7:0];
      walk_we = 1'b0; walk_wa = next_ff[7:0]; walk_wcode = '0; walk_wdepth = '0;
      code_re = 1'b0; code_ra = req_data_byte; code_clr = 1'b0;
      code_we = 1'b0; code_wa = child[7:0]; code_wword = child_code;
      code_wlen = child_depth[6:0];

      cur_w  = x_ff.weight;
      pick_l = 1'b0;
      pick_r = 1'b0;

      rsp_d = '0;
      emit  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = req_data_byte;
               case (req_command)
                  hbe_pkg::CMD_CLEAR: begin
                     hist_clr    = 1'b1;
                     code_clr    = 1'b1;
                     distinct_in = '0;
                     total_in    = '0;
                     buf_in      = '0;
                     pend_in     = '0;
                     ready_in    = 1'b0;
                  end
                  hbe_pkg::CMD_COUNT: begin
                     hist_re = 1'b1;
                     if ({1'b0, req_data_byte} < 9'(hbe_pkg::SYMBOLS)) state_in = S_CNT;
                  end
                  hbe_pkg::CMD_BUILD: begin
                     code_clr = 1'b1;
                     size_in  = '0;
                     s_in     = '0;
                     next_in  = 9'd256;
                     state_in = S_SCAN_RD;
                  end
                  hbe_pkg::CMD_ENCODE: begin
                     code_re  = 1'b1;
                     state_in = S_ENC;
                  end
                  hbe_pkg::CMD_FLUSH: state_in = S_FLUSH;
                  hbe_pkg::CMD_FREQ: begin
                     hist_re  = 1'b1;
                     state_in = S_FREQ;
                  end
                  default: ;
               endcase
            end
         end
         S_CNT: begin
            hist_we = 1'b1;
            if (hist_val == 32'd0) distinct_in = distinct_ff + 9'd1;
            else if (hist_inc == 32'd0) distinct_in = distinct_ff - 9'd1;
            if (total_ff != TOTAL_MAX) total_in = total_ff + 48'd1;
            state_in = S_IDLE;
         end
         S_FREQ: begin
            if (out_free) begin
               rsp_d.result_kind = hbe_pkg::KIND_FREQ;
               rsp_d.frequency   = sym_ok ? hist_val : 32'd0;
               rsp_d.last        = 1'b1;
               emit.valid        = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_ENC: begin
            if (!ready_ff || !sym_ok || !cv_rd_ff || cl_rd_ff == 7'd0) begin
               if (out_free) begin
                  rsp_d.result_kind = hbe_pkg::KIND_BYTE;
                  rsp_d.error       = 1'b1;
                  rsp_d.last        = 1'b1;
                  emit.valid        = 1'b1;
                  state_in          = S_IDLE;
               end
            end else begin
               // left-align the code so the next bit is always bit 63
               al_in    = cw_rd_ff << 6'(7'd64 - cl_rd_ff);
               bits_in  = cl_rd_ff;
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            if (pend_sum == 4'd8) begin
               if (out_free) begin
                  rsp_d.result_kind = hbe_pkg::KIND_BYTE;
                  rsp_d.out_byte    = combo[15:8];
                  rsp_d.last        = (rem < 7'd8);
                  emit.valid        = 1'b1;
                  buf_in  = '0;
                  pend_in = '0;
                  al_in   = al_ff << take;
                  bits_in = rem;
                  if (rem == 7'd0) state_in = S_IDLE;
               end
            end else begin
               buf_in   = combo[15:8];
               pend_in  = pend_sum[2:0];
               al_in    = al_ff << take;
               bits_in  = rem;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (pend_ff == 3'd0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_d.result_kind = hbe_pkg::KIND_BYTE;
               rsp_d.out_byte    = buf_ff << 3'(4'd8 - {1'b0, pend_ff});
               rsp_d.last        = 1'b1;
               emit.valid        = 1'b1;
               buf_in   = '0;
               pend_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            hist_re  = 1'b1;
            hist_ra  = s_ff;
            state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            if (hist_val != 32'd0) begin
               ins_in   = '{weight: hist_val, node: {1'b0, s_ff}};
               ins_i_in = size_ff[7:0];
               size_in  = size_ff + 9'd1;
               ret_in   = S_SCAN_NX;
               state_in = S_INS_RD;
            end else begin
               state_in = S_SCAN_NX;
            end
         end
         S_SCAN_NX: begin
            if (s_ff == 8'(hbe_pkg::SYMBOLS - 1)) begin
               state_in = S_AFTER;
            end else begin
               s_in     = s_ff + 8'd1;
               state_in = S_SCAN_RD;
            end
         end
         S_AFTER: begin
            if (size_ff == 9'd0) begin
               state_in = S_DONE;
            end else if (size_ff == 9'd1) begin
               heap_re  = 1'b1;
               state_in = S_LONE;
            end else begin
               ret_in   = S_M_A;
               state_in = S_EX0;
            end
         end
         S_LONE: begin
            // a lone symbol gets the one-bit code 0
            code_we    = 1'b1;
            code_wa    = heap_rd_ff.node[7:0];
            code_wword = '0;
            code_wlen  = 7'd1;
            state_in   = S_DONE;
         end
         S_INS_RD: begin
            if (ins_i_ff == 8'd0) begin
               heap_we  = 1'b1;
               heap_wa  = '0;
               state_in = ret_ff;
            end else begin
               heap_re  = 1'b1;
               heap_ra  = parent[8:1];
               state_in = S_INS_CK;
            end
         end
         S_INS_CK: begin
            heap_we = 1'b1;
            heap_wa = ins_i_ff;
            if (ins_ff.weight < heap_rd_ff.weight) begin
               heap_wd  = heap_rd_ff;
               ins_i_in = parent[8:1];
               state_in = S_INS_RD;
            end else begin
               state_in = ret_ff;
            end
         end
         S_EX0: begin
            heap_re  = 1'b1;
            state_in = S_EX1;
         end
         S_EX1: begin
            top_in   = heap_rd_ff;
            heap_re  = 1'b1;
            heap_ra  = 8'(size_ff - 9'd1);
            state_in = S_EX2;
         end
         S_EX2: begin
            x_in     = heap_rd_ff;
            size_in  = size_ff - 9'd1;
            sd_i_in  = '0;
            state_in = S_SD_L;
         end
         S_SD_L: begin
            if (l_idx < size_ff) begin
               heap_re  = 1'b1;
               heap_ra  = l_idx[7:0];
               state_in = S_SD_R;
            end else begin
               heap_we  = 1'b1;
               heap_wa  = sd_i_ff;
               heap_wd  = x_ff;
               state_in = ret_ff;
            end
         end
         S_SD_R: begin
            hl_in = heap_rd_ff;
            if (r_idx < {1'b0, size_ff}) begin
               heap_re = 1'b1;
               heap_ra = r_idx[7:0];
               rv_in   = 1'b1;
            end else begin
               rv_in = 1'b0;
            end
            state_in = S_SD_CK;
         end
         S_SD_CK: begin
            // strict less-than, left child checked first
            if (hl_ff.weight < cur_w) begin
               pick_l = 1'b1;
               cur_w  = hl_ff.weight;
            end
            if (rv_ff && heap_rd_ff.weight < cur_w) pick_r = 1'b1;
            heap_we = 1'b1;
            heap_wa = sd_i_ff;
            if (pick_r) begin
               heap_wd  = heap_rd_ff;
               sd_i_in  = r_idx[7:0];
               state_in = S_SD_L;
            end else if (pick_l) begin
               heap_wd  = hl_ff;
               sd_i_in  = l_idx[7:0];
               state_in = S_SD_L;
            end else begin
               heap_wd  = x_ff;
               state_in = ret_ff;
            end
         end
         S_M_A: begin
            a_in     = top_ff;
            ret_in   = S_M_B;
            state_in = S_EX0;
         end
         S_M_B: begin
            kid_we   = 1'b1;
            ins_in   = '{weight: a_ff.weight + top_ff.weight, node: next_ff};
            ins_i_in = size_ff[7:0];
            size_in  = size_ff + 9'd1;
            ret_in   = S_M_NX;
            state_in = S_INS_RD;
         end
         S_M_NX: begin
            if (size_ff > 9'd1) begin
               next_in  = next_ff + 9'd1;
               ret_in   = S_M_A;
               state_in = S_EX0;
            end else begin
               // root: empty code at depth zero
               walk_we  = 1'b1;
               state_in = S_W_RD;
            end
         end
         S_W_RD: begin
            walk_re  = 1'b1;
            state_in = S_W_C0;
         end
         S_W_C0, S_W_C1: begin
            if (child[8]) begin
               walk_we     = 1'b1;
               walk_wa     = child[7:0];
               walk_wcode  = child_code;
               walk_wdepth = child_depth;
            end else if (child_depth <= 8'(hbe_pkg::MAX_CODE_BITS)) begin
               code_we = 1'b1;
            end
            if (state_ff == S_W_C0) begin
               state_in = S_W_C1;
            end else if (next_ff == 9'd256) begin
               state_in = S_DONE;
            end else begin
               next_in  = next_ff - 9'd1;
               state_in = S_W_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_d.result_kind  = hbe_pkg::KIND_SUMMARY;
               rsp_d.symbol_count = distinct_ff;
               rsp_d.total_count  = total_ff;
               rsp_d.last         = 1'b1;
               emit.valid         = 1'b1;
               ready_in = 1'b1;
               buf_in   = '0;
               pend_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      emit.data = rsp_d;
   end

   // memories
   always_ff @(posedge clock) begin
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_ra];
         hv_rd_ff   <= hv_ff[hist_ra];
      end
      if (hist_we) hist_mem[hist_wa] <= hist_wd;
   end

   always_ff @(posedge clock) begin
      if (heap_re) heap_rd_ff <= heap_mem[heap_ra];
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
   end

   always_ff @(posedge clock) begin
      if (walk_re) begin
         kid_l_rd_ff      <= kid_l_mem[walk_ra];
         kid_r_rd_ff      <= kid_r_mem[walk_ra];
         walk_code_rd_ff  <= walk_code_mem[walk_ra];
         walk_depth_rd_ff <= walk_depth_mem[walk_ra];
      end
      if (kid_we) begin
         kid_l_mem[kid_wa] <= kid_wl;
         kid_r_mem[kid_wa] <= kid_wr;
      end
      if (walk_we) begin
         walk_code_mem[walk_wa]  <= walk_wcode;
         walk_depth_mem[walk_wa] <= walk_wdepth;
      end
   end

   always_ff @(posedge clock) begin
      if (code_re) begin
         cw_rd_ff <= code_word_mem[code_ra];
         cl_rd_ff <= code_len_mem[code_ra];
         cv_rd_ff <= cv_ff[code_ra];
      end
      if (code_we) begin
         code_word_mem[code_wa] <= code_wword;
         code_len_mem[code_wa]  <= code_wlen;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         hv_ff       <= '0;
         cv_ff       <= '0;
         distinct_ff <= '0;
         total_ff    <= '0;
         buf_ff      <= '0;
         pend_ff     <= '0;
         ready_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         distinct_ff <= distinct_in;
         total_ff    <= total_in;
         buf_ff      <= buf_in;
         pend_ff     <= pend_in;
         ready_ff    <= ready_in;
         if (hist_clr) hv_ff <= '0;
         else if (hist_we) hv_ff[hist_wa] <= 1'b1;
         if (code_clr) cv_ff <= '0;
         else if (code_we) cv_ff[code_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      byte_ff  <= byte_in;
      size_ff  <= size_in;
      s_ff     <= s_in;
      next_ff  <= next_in;
      ins_i_ff <= ins_i_in;
      sd_i_ff  <= sd_i_in;
      ins_ff   <= ins_in;
      top_ff   <= top_in;
      x_ff     <= x_in;
      a_ff     <= a_in;
      hl_ff    <= hl_in;
      rv_ff    <= rv_in;
      al_ff    <= al_in;
      bits_ff  <= bits_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/huffman_byte_encoder_top.sv =====
// Top level of the Huffman byte encoder: result register and channels.
// Depends on hbe_pkg, hbe_req_if, hbe_rsp_if and hbe_core.
// One item at a time. Encode emits each full byte that it packs and keeps the
// leftover bits in the buffer. Build: histogram scan of 256 steps plus heap
// work per level, every step one port of the heap memory. Results wait
// while the result register is full.
// Synchronous reset clears histogram and code tables through valid bits at
// once; no clearing pass. Clear does the same.
`default_nettype none
module huffman_byte_encoder_top (
   input  wire logic clock,
   input  wire logic reset,
   hbe_req_if.sink   req,
   hbe_rsp_if.source rsp
);

   hbe_pkg::emit_type emit;
   hbe_pkg::rsp_type  rsp_data_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;

   hbe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_command   (req.command),
      .req_data_byte (req.data_byte),
      .out_free      (out_free),
      .emit          (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) rsp_data_ff <= emit.data;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = rsp_data_ff.result_kind;
   assign rsp.out_byte     = rsp_data_ff.out_byte;
   assign rsp.symbol_count = rsp_data_ff.symbol_count;
   assign rsp.total_count  = rsp_data_ff.total_count;
   assign rsp.frequency    = rsp_data_ff.frequency;
   assign rsp.error        = rsp_data_ff.error;
   assign rsp.last         = rsp_data_ff.last;

endmodule
`default_nettype wire

// ===== sim/hbe_encoder_checker.sv =====
// Checker for the Huffman byte encoder: watches both channels, predicts the results
// and compares them. Depends on hbe_pkg, hbe_req_if and hbe_rsp_if.
module hbe_encoder_checker
   import hbe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   hbe_req_if        req,
   hbe_rsp_if        rsp,
   output int        mismatches,
   output int        outstanding,
   output int        results_seen,
   output int        builds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] hist [256];
   logic [63:0] code_bits [256];
   int          code_len [256];
   int          distinct;
   logic [47:0] byte_total;
   logic [7:0]  pack_buf;
   int          pack_cnt;
   bit          table_valid;

   logic [31:0] wt [511];
   logic [8:0]  left_of [511];
   logic [8:0]  right_of [511];
   logic [8:0]  heap [256];
   int          heap_cnt;
   logic [63:0] path_bits [511];
   int          path_len [511];

   rsp_type expected_q [$];

   function automatic void clear_state();
      for (int s = 0; s < 256; s++) begin
         hist[s] = '0;
         code_len[s] = 0;
      end
      distinct = 0;
      byte_total = '0;
      pack_buf = '0;
      pack_cnt = 0;
      table_valid = 0;
   endfunction

   function automatic void heap_push(logic [8:0] node);
      int i;
      i = heap_cnt;
      heap_cnt++;
      while (i != 0 && wt[node] < wt[heap[(i - 1) / 2]]) begin
         heap[i] = heap[(i - 1) / 2];
         i = (i - 1) / 2;
      end
      heap[i] = node;
   endfunction

   function automatic logic [8:0] heap_pop();
      logic [8:0] top;
      logic [8:0] t;
      int i;
      int sm;
      top = heap[0];
      heap[0] = heap[heap_cnt - 1];
      heap_cnt--;
      i = 0;
      forever begin
         sm = i;
         if (2 * i + 1 < heap_cnt && wt[heap[2 * i + 1]] < wt[heap[sm]]) sm = 2 * i + 1;
         if (2 * i + 2 < heap_cnt && wt[heap[2 * i + 2]] < wt[heap[sm]]) sm = 2 * i + 2;
         if (sm == i) break;
         t = heap[sm];
         heap[sm] = heap[i];
         heap[i] = t;
         i = sm;
      end
      return top;
   endfunction

   function automatic void assign_code(logic [8:0] leaf, logic [63:0] bits, int depth);
      if (depth >= 1 && depth <= MAX_CODE_BITS) begin
         code_bits[leaf] = bits;
         code_len[leaf] = depth;
      end
   endfunction

   function automatic void build_code_table();
      int next_node;
      logic [8:0] a;
      logic [8:0] b;
      logic [8:0] kid;
      logic [63:0] bits;
      int n;
      for (int s = 0; s < 256; s++) code_len[s] = 0;
      heap_cnt = 0;
      next_node = 256;
      for (int s = 0; s < SYMBOLS; s++) begin
         if (hist[s] != 0) begin
            wt[s] = hist[s];
            heap_push(9'(s));
         end
      end
      if (heap_cnt == 1) begin
         a = heap_pop();
         assign_code(a, '0, 1);
         return;
      end
      if (heap_cnt == 0) return;
      while (heap_cnt > 1) begin
         a = heap_pop();
         b = heap_pop();
         wt[next_node] = wt[a] + wt[b];
         left_of[next_node] = a;
         right_of[next_node] = b;
         heap_push(9'(next_node));
         next_node++;
      end
      a = heap_pop();
      path_bits[next_node - 1] = '0;
      path_len[next_node - 1] = 0;
      // parents always come after their children, so walk down from the root
      for (int k = next_node; k > 256; k--) begin
         n = k - 1;
         for (int j = 0; j < 2; j++) begin
            kid = (j == 0) ? left_of[n] : right_of[n];
            bits = {path_bits[n][62:0], 1'(j)};
            if (kid >= 256) begin
               path_bits[kid] = bits;
               path_len[kid] = path_len[n] + 1;
            end else begin
               assign_code(kid, bits, path_len[n] + 1);
            end
         end
      end
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [7:0] ob, logic err);
      rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.out_byte = ob;
      r.error = err;
      return r;
   endfunction

   function automatic void encoder_step(logic [2:0] cmd, logic [7:0] b);
      rsp_type produced [$];
      rsp_type r;
      logic [31:0] bump;
      case (cmd)
         CMD_CLEAR: clear_state();
         CMD_COUNT: begin
            if (hist[b] == 0) distinct++;
            bump = hist[b] + 32'd1;
            hist[b] = bump;
            if (bump == 0) distinct--;
            if (byte_total != '1) byte_total++;
         end
         CMD_BUILD: begin
            build_code_table();
            table_valid = 1;
            pack_buf = '0;
            pack_cnt = 0;
            r = make_rsp(KIND_SUMMARY, '0, 1'b0);
            r.symbol_count = 9'(distinct);
            r.total_count = byte_total;
            produced.push_back(r);
         end
         CMD_ENCODE: begin
            if (!table_valid || code_len[b] == 0) begin
               produced.push_back(make_rsp(KIND_BYTE, '0, 1'b1));
            end else begin
               for (int i = code_len[b] - 1; i >= 0; i--) begin
                  pack_buf = {pack_buf[6:0], code_bits[b][i]};
                  pack_cnt++;
                  if (pack_cnt == 8) begin
                     produced.push_back(make_rsp(KIND_BYTE, pack_buf, 1'b0));
                     pack_buf = '0;
                     pack_cnt = 0;
                  end
               end
            end
         end
         CMD_FLUSH: begin
            if (pack_cnt != 0) begin
               produced.push_back(make_rsp(KIND_BYTE, pack_buf << (8 - pack_cnt), 1'b0));
               pack_buf = '0;
               pack_cnt = 0;
            end
         end
         CMD_FREQ: begin
            r = make_rsp(KIND_FREQ, '0, 1'b0);
            r.frequency = hist[b];
            produced.push_back(r);
         end
         default: ;
      endcase
      if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i]) expected_q.push_back(produced[i]);
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      results_seen = 0;
      builds_seen = 0;
      clear_state();
   end

   assign outstanding = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_state();
         expected_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("unexpected result transfer, kind %0d", rsp.result_kind);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (want.result_kind == KIND_SUMMARY) builds_seen++;
               check_field("result_kind", want.result_kind, rsp.result_kind);
               check_field("out_byte", want.out_byte, rsp.out_byte);
               check_field("symbol_count", want.symbol_count, rsp.symbol_count);
               check_field("total_count", want.total_count, rsp.total_count);
               check_field("frequency", want.frequency, rsp.frequency);
               check_field("error", want.error, rsp.error);
               check_field("last", want.last, rsp.last);
            end
         end
         if (req.valid && req.ready) encoder_step(req.command, req.data_byte);
      end
   end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the Huffman byte encoder: clock, reset, stimulus and verdict.
// Depends on hbe_pkg, the channel interfaces, hbe_encoder_checker and the block.
module tb;
   import hbe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;

   logic clock;
   logic reset;
   int   mismatches, outstanding, results_seen, builds_seen;
   int   idle_pct, stall_pct, hold_cycles, items_sent, quiet_cycles;
   logic [7:0] alphabet [$];

   hbe_req_if req_ch ();
   hbe_rsp_if rsp_ch ();

   huffman_byte_encoder_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   hbe_encoder_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .builds_seen  (builds_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send(logic [2:0] cmd, logic [7:0] b);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.command <= cmd;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 0;
      while (outstanding != 0) @(posedge clock);
   endtask

   // skewed pick from the session's alphabet so weights differ and ties occur
   function automatic logic [7:0] pick_symbol();
      int r;
      r = $urandom_range(alphabet.size() - 1);
      if ($urandom_range(1)) r = r / 2;
      return alphabet[r];
   endfunction

   task automatic coding_session(int n_count, int n_encode);
      int width;
      logic [7:0] s;
      width = $urandom_range(1, 12);
      if ($urandom_range(4) == 0) width = $urandom_range(20, 60);
      alphabet.delete();
      for (int i = 0; i < width; i++) alphabet.push_back(8'($urandom));
      send(CMD_CLEAR, 8'($urandom));
      for (int i = 0; i < n_count; i++) send(CMD_COUNT, pick_symbol());
      send(CMD_BUILD, 8'($urandom));
      send(CMD_FREQ, pick_symbol());
      for (int i = 0; i < n_encode; i++) begin
         s = ($urandom_range(9) == 0) ? 8'($urandom) : pick_symbol();
         case ($urandom_range(19))
            0: send(CMD_FLUSH, 8'($urandom));
            1: send(CMD_COUNT, s);                       // old codes stay in use
            2: send(CMD_FREQ, s);
            3: send(3'($urandom_range(6, 7)), 8'($urandom));
            default: send(CMD_ENCODE, s);
         endcase
      end
      send(CMD_FLUSH, 8'($urandom));
   endtask

   initial begin
      logic [7:0] fib_sym [8];
      int fib_w [8];
      reset = 1;
      req_ch.valid = 0;
      req_ch.command = CMD_CLEAR;
      req_ch.data_byte = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: nothing built yet, empty tree, lone symbol, unused codes
      send(CMD_ENCODE, 8'h00);
      send(CMD_FLUSH, 8'hff);
      send(3'd6, 8'h55);
      send(3'd7, 8'haa);
      send(CMD_FREQ, 8'h00);
      send(CMD_BUILD, 8'h00);
      send(CMD_ENCODE, 8'hff);
      send(CMD_COUNT, 8'hff);
      send(CMD_COUNT, 8'hff);
      send(CMD_FREQ, 8'hff);
      send(CMD_ENCODE, 8'hff);
      send(CMD_BUILD, 8'h00);
      for (int i = 0; i < 9; i++) send(CMD_ENCODE, 8'hff);
      send(CMD_ENCODE, 8'h00);
      send(CMD_FLUSH, 8'h00);
      send(CMD_FLUSH, 8'h00);
      send(CMD_COUNT, 8'h00);
      send(CMD_BUILD, 8'h80);
      send(CMD_ENCODE, 8'h00);
      send(CMD_ENCODE, 8'hff);
      send(CMD_FLUSH, 8'h00);
      send(CMD_CLEAR, 8'h00);
      send(CMD_FREQ, 8'hff);

      // Fibonacci weights give a deep, lopsided tree and long codes that cross byte boundaries
      send(CMD_CLEAR, 8'h00);
      fib_w = '{1, 1, 2, 3, 5, 8, 13, 21};
      for (int i = 0; i < 8; i++) fib_sym[i] = 8'($urandom);
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < fib_w[i]; j++) send(CMD_COUNT, fib_sym[i]);
      send(CMD_BUILD, 8'h00);
      for (int i = 0; i < 24; i++) send(CMD_ENCODE, fib_sym[$urandom_range(2)]);
      wait_drained();

      // receiver holds off while encodes keep coming, so the block backs up
      hold_cycles = 400;
      for (int i = 0; i < 16; i++) send(CMD_ENCODE, fib_sym[$urandom_range(7)]);
      send(CMD_FLUSH, 8'h00);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         coding_session($urandom_range(15, 30), 20);
         wait_drained();
         idle_pct = 0;
         stall_pct = 0;
         repeat ($urandom_range(0, 4)) coding_session(0, 0);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over four idle/stall phases; checked %0d results",
               items_sent, results_seen);
      $display("including %0d code table builds.", builds_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
